// ===== design/integer_to_ascii_formatter_assert.svh =====
// Assertion macros for the integer to ASCII formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle check, quiet while reset is asserted
`define IAFMT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check in the cycle after the trigger
`define IAFMT_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

// ===== design/iafmt_pkg.sv =====
// Shared types and constants of the integer to ASCII formatter
`timescale 1ns / 1ps
`default_nettype none
package iafmt_pkg;

	localparam int VAL_BITS    = 32;
	localparam int DEC_DIGITS  = 10;
	localparam int BCD_BITS    = 4 * DEC_DIGITS;
	localparam int OCT_DIGITS  = 11;
	localparam int OCT_BITS    = 3 * OCT_DIGITS;
	localparam int HEX_NIBBLES = 8;

	typedef enum logic [2:0] {
		ACT_SDEC = 3'd0,
		ACT_UDEC = 3'd1,
		ACT_OCT  = 3'd2,
		ACT_HEX  = 3'd3,
		ACT_PTR  = 3'd4,
		ACT_CHAR = 3'd5
	} action_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bcd_status_t;

endpackage
`default_nettype wire

// ===== design/iafmt_if.sv =====
// Valid/ready channels carrying input items and output characters
`timescale 1ns / 1ps
`default_nettype none
interface iafmt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [63:0] value;

	modport source (output valid, action, value, input ready);
	modport sink   (input valid, action, value, output ready);
endinterface

interface iafmt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink   (input valid, out_char, last_char, output ready);
endinterface
`default_nettype wire

// ===== design/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter
`timescale 1ns / 1ps
`default_nettype none
// Takes one item (action, value) and returns its text one character per output
// transaction, most significant character first, with last_char on the final one.
// One item is worked on at a time. Octal, hex and pointer digits are shifted out of
// one digit register, one digit per cycle while the output is not stalled, with
// leading zeros dropped one per cycle first. Decimal items first pass through the
// bit-serial BCD converter, one shift per input bit, before the digits are loaded.
// A stalled output holds the item back until the character is taken.
// Actions 6 and 7 are dropped.
module integer_to_ascii_formatter #(
	parameter int POINTER_BITS = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	iafmt_in_if.sink    din,
	iafmt_out_if.source dout
);

	`include "integer_to_ascii_formatter_assert.svh"

	localparam int PTR_DIGITS = (POINTER_BITS + 3) / 4;
	localparam int NDIG = (PTR_DIGITS > iafmt_pkg::OCT_DIGITS) ? PTR_DIGITS
		: iafmt_pkg::OCT_DIGITS;
	localparam int DW = 4 * NDIG;
	localparam int RW = $clog2(NDIG + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_PREFIX,
		S_SKIP,
		S_DIGIT
	} state_t;

	typedef enum logic [1:0] {
		PRE_MINUS,
		PRE_HEX,
		PRE_NULL,
		PRE_CHAR
	} pre_kind_t;

	state_t                          state_q;
	pre_kind_t                       pre_kind_q;
	logic [2:0]                      pre_idx_q;
	logic [2:0]                      action_q;
	logic                            neg_q;
	logic [7:0]                      byte_q;
	logic [DW-1:0]                   digits_q;
	logic [RW-1:0]                   rem_q;
	logic                            out_valid_q;
	logic [7:0]                      out_char_q;
	logic                            out_last_q;

	logic                            accept;
	logic [iafmt_pkg::VAL_BITS-1:0]  low;
	logic                            in_neg;
	logic [iafmt_pkg::VAL_BITS-1:0]  mag;
	logic                            bcd_start;
	iafmt_pkg::bcd_status_t          bcd_st;
	logic [iafmt_pkg::BCD_BITS-1:0]  bcd;
	logic                            is_oct;
	logic [3:0]                      cur_digit;
	logic [DW-1:0]                   digits_shifted;
	logic [7:0]                      digit_char;
	logic [7:0]                      pre_char;
	logic                            pre_final;
	logic                            can_emit;
	logic                            emit_fire;
	logic                            emit_last;
	logic [7:0]                      emit_char;

	assign accept    = din.valid && din.ready;
	assign low       = din.value[iafmt_pkg::VAL_BITS-1:0];
	assign in_neg    = (din.action == iafmt_pkg::ACT_SDEC) && low[iafmt_pkg::VAL_BITS-1];
	assign mag       = in_neg ? (~low + 1'b1) : low;
	assign bcd_start = accept && ((din.action == iafmt_pkg::ACT_SDEC)
		|| (din.action == iafmt_pkg::ACT_UDEC));

	iafmt_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (mag),
		.status (bcd_st),
		.bcd    (bcd)
	);

	assign is_oct         = (action_q == iafmt_pkg::ACT_OCT);
	assign cur_digit      = is_oct ? {1'b0, digits_q[DW-1 -: 3]} : digits_q[DW-1 -: 4];
	assign digits_shifted = is_oct ? (digits_q << 3) : (digits_q << 4);

	always_comb begin
		if (cur_digit < 4'd10) begin
			digit_char = 8'(cur_digit) + 8'h30;
		end else if (action_q == iafmt_pkg::ACT_HEX) begin
			digit_char = 8'(cur_digit) + 8'h37;
		end else begin
			digit_char = 8'(cur_digit) + 8'h57;
		end
	end

	always_comb begin
		pre_char  = byte_q;
		pre_final = 1'b1;
		case (pre_kind_q)
			PRE_MINUS: begin
				pre_char = 8'h2d;
			end
			PRE_HEX: begin
				pre_char  = (pre_idx_q == 3'd0) ? 8'h30 : 8'h78;
				pre_final = (pre_idx_q == 3'd1);
			end
			PRE_NULL: begin
				pre_final = (pre_idx_q == 3'd5);
				case (pre_idx_q)
					3'd0:    pre_char = 8'h28;
					3'd1:    pre_char = 8'h6e;
					3'd2:    pre_char = 8'h75;
					3'd3:    pre_char = 8'h6c;
					3'd4:    pre_char = 8'h6c;
					default: pre_char = 8'h29;
				endcase
			end
			default: begin
				pre_char = byte_q;
			end
		endcase
	end

	assign can_emit  = !out_valid_q || dout.ready;
	assign emit_fire = can_emit && ((state_q == S_PREFIX) || (state_q == S_DIGIT));
	assign emit_last = (state_q == S_PREFIX)
		? (pre_final && ((pre_kind_q == PRE_NULL) || (pre_kind_q == PRE_CHAR)))
		: (rem_q == RW'(1));
	assign emit_char = (state_q == S_PREFIX) ? pre_char : digit_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pre_kind_q  <= PRE_MINUS;
			pre_idx_q   <= '0;
			action_q    <= '0;
			neg_q       <= 1'b0;
			byte_q      <= '0;
			digits_q    <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
				out_char_q  <= emit_char;
				out_last_q  <= emit_last;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						action_q  <= din.action;
						neg_q     <= in_neg;
						byte_q    <= din.value[7:0];
						pre_idx_q <= '0;
						case (din.action)
							iafmt_pkg::ACT_SDEC, iafmt_pkg::ACT_UDEC: begin
								state_q <= S_CONV;
							end
							iafmt_pkg::ACT_OCT: begin
								digits_q <= DW'({1'b0, low}) << (DW - iafmt_pkg::OCT_BITS);
								rem_q    <= RW'(iafmt_pkg::OCT_DIGITS);
								state_q  <= S_SKIP;
							end
							iafmt_pkg::ACT_HEX: begin
								digits_q <= DW'(low) << (DW - iafmt_pkg::VAL_BITS);
								rem_q    <= RW'(iafmt_pkg::HEX_NIBBLES);
								state_q  <= S_SKIP;
							end
							iafmt_pkg::ACT_PTR: begin
								digits_q <= DW'(din.value[POINTER_BITS-1:0])
									<< (DW - 4 * PTR_DIGITS);
								rem_q    <= RW'(PTR_DIGITS);
								if (din.value[POINTER_BITS-1:0] == '0) begin
									pre_kind_q <= PRE_NULL;
								end else begin
									pre_kind_q <= PRE_HEX;
								end
								state_q <= S_PREFIX;
							end
							iafmt_pkg::ACT_CHAR: begin
								pre_kind_q <= PRE_CHAR;
								state_q    <= S_PREFIX;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CONV: begin
					if (bcd_st.done) begin
						digits_q <= DW'(bcd) << (DW - iafmt_pkg::BCD_BITS);
						rem_q    <= RW'(iafmt_pkg::DEC_DIGITS);
						if (neg_q) begin
							pre_kind_q <= PRE_MINUS;
							state_q    <= S_PREFIX;
						end else begin
							state_q <= S_SKIP;
						end
					end
				end
				S_PREFIX: begin
					if (can_emit) begin
						pre_idx_q <= pre_idx_q + 3'd1;
						if (pre_final) begin
							state_q <= emit_last ? S_IDLE : S_SKIP;
						end
					end
				end
				S_SKIP: begin
					// drop leading zeros, keep at least one digit
					if ((cur_digit == 4'd0) && (rem_q != RW'(1))) begin
						digits_q <= digits_shifted;
						rem_q    <= rem_q - RW'(1);
					end else begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (can_emit) begin
						digits_q <= digits_shifted;
						rem_q    <= rem_q - RW'(1);
						if (rem_q == RW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign din.ready      = (state_q == S_IDLE);
	assign dout.valid     = out_valid_q;
	assign dout.out_char  = out_char_q;
	assign dout.last_char = out_last_q;

	`IAFMT_ASSERT(a_bcd_done_in_conv, !bcd_st.done || (state_q == S_CONV), "BCD result arrived outside conversion")
	`IAFMT_ASSERT(a_digits_left, ((state_q != S_SKIP) && (state_q != S_DIGIT)) || (rem_q != '0), "digit phase with no digits left")
	`IAFMT_ASSERT_NEXT(a_last_ends_item, emit_fire && emit_last, state_q == S_IDLE, "final character did not end the item")

endmodule
`default_nettype wire

// ===== design/iafmt_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add three)
`timescale 1ns / 1ps
`default_nettype none
module iafmt_bcd (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [iafmt_pkg::VAL_BITS-1:0]  bin,
	output iafmt_pkg::bcd_status_t               status,
	output logic      [iafmt_pkg::BCD_BITS-1:0]  bcd
);

	localparam int CW = $clog2(iafmt_pkg::VAL_BITS + 1);

	logic [iafmt_pkg::VAL_BITS-1:0] bin_q;
	logic [iafmt_pkg::BCD_BITS-1:0] bcd_q;
	logic [iafmt_pkg::BCD_BITS-1:0] adj;
	logic [CW-1:0]                  cnt_q;
	logic                           busy_q;
	logic                           done_q;

	// Correct every decimal digit before the next shift
	always_comb begin
		for (int i = 0; i < iafmt_pkg::DEC_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			bcd_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				bin_q  <= bin;
				bcd_q  <= '0;
				cnt_q  <= CW'(iafmt_pkg::VAL_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				bcd_q <= {adj[iafmt_pkg::BCD_BITS-2:0], bin_q[iafmt_pkg::VAL_BITS-1]};
				bin_q <= bin_q << 1;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign bcd         = bcd_q;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the integer to ASCII formatter
`timescale 1ns / 1ps
module tb_top;

	localparam int POINTER_BITS = 64;
	localparam logic [63:0] PTR_MASK = (POINTER_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
		((64'd1 << POINTER_BITS) - 64'd1);
	localparam logic [127:0] DIGITS_LOWER = "0123456789abcdef";
	localparam logic [127:0] DIGITS_UPPER = "0123456789ABCDEF";
	localparam logic [47:0]  NULL_TEXT = "(null)";
	localparam int RANDOM_ITEMS = 96;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] value;
	} fmt_req_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [2:0]  in_action = '0;
	logic [63:0] in_value = '0;
	logic        out_ready = 1'b0;

	iafmt_in_if  din_bus ();
	iafmt_out_if dout_bus ();

	assign din_bus.valid  = in_valid;
	assign din_bus.action = in_action;
	assign din_bus.value  = in_value;
	assign dout_bus.ready = out_ready;

	integer_to_ascii_formatter #(
		.POINTER_BITS(POINTER_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_bus),
		.dout(dout_bus)
	);

	fmt_req_t   req_queue [$];
	text_char_t expected_text [$];
	fmt_req_t   next_req;
	text_char_t want;
	logic       in_taken = 1'b0;
	int         gap_left = 0;
	int         burst_left = 0;
	logic [31:0] stall_mask = '1;
	int         stall_phase = 0;
	int         error_count = 0;
	int         cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the characters an item should produce and queue them up
	function automatic void format_text(input logic [2:0] act, input logic [63:0] val);
		logic [7:0]  txt [0:19];
		logic [7:0]  rev [0:23];
		logic [63:0] mag;
		logic [63:0] radix;
		logic [31:0] low;
		logic        upper;
		logic        has_digits;
		int          len;
		int          nd;
		int          dig;
		int          i;
		text_char_t  c;
		low = val[31:0];
		mag = {32'd0, low};
		radix = 64'd10;
		upper = 1'b0;
		has_digits = 1'b1;
		len = 0;
		nd = 0;
		case (act)
			iafmt_pkg::ACT_SDEC: begin
				if (low[31]) begin
					txt[0] = "-";
					len = 1;
					mag = {32'd0, ~low + 32'd1};
				end
			end
			iafmt_pkg::ACT_UDEC: ;
			iafmt_pkg::ACT_OCT: radix = 64'd8;
			iafmt_pkg::ACT_HEX: begin
				radix = 64'd16;
				upper = 1'b1;
			end
			iafmt_pkg::ACT_PTR: begin
				mag = val & PTR_MASK;
				radix = 64'd16;
				if (mag == 64'd0) begin
					for (i = 0; i < 6; i++)
						txt[i] = NULL_TEXT[47 - 8 * i -: 8];
					len = 6;
					has_digits = 1'b0;
				end else begin
					txt[0] = "0";
					txt[1] = "x";
					len = 2;
				end
			end
			iafmt_pkg::ACT_CHAR: begin
				txt[0] = val[7:0];
				len = 1;
				has_digits = 1'b0;
			end
			default: has_digits = 1'b0;
		endcase
		if (has_digits) begin
			// least significant digit first, then reverse
			do begin
				dig = int'(mag % radix);
				rev[nd] = upper ? DIGITS_UPPER[127 - 8 * dig -: 8] : DIGITS_LOWER[127 - 8 * dig -: 8];
				nd++;
				mag = mag / radix;
			end while (mag != 64'd0);
			for (i = nd - 1; i >= 0; i--) begin
				txt[len] = rev[i];
				len++;
			end
		end
		for (i = 0; i < len; i++) begin
			c.ch = txt[i];
			c.last = (i == len - 1);
			expected_text.push_back(c);
		end
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic push_req(input logic [2:0] act, input logic [63:0] val);
		fmt_req_t r;
		r.action = act;
		r.value = val;
		req_queue.push_back(r);
	endtask

	// Sender: bursts of items separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (req_queue.size() > 0) begin
				next_req = req_queue.pop_front();
				in_action <= next_req.action;
				in_value <= next_req.value;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 6);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: ready follows the bits of a 32-bit mask, reloaded with a fresh pattern each time
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				case ($urandom_range(0, 3))
					0: stall_mask = '1;
					1: stall_mask = $urandom;
					2: stall_mask = $urandom | $urandom;
					default: stall_mask = $urandom & $urandom;
				endcase
				stall_phase = 32;
			end
			stall_phase--;
			out_ready <= stall_mask[stall_phase];
		end
	end

	// Check each output transaction, then predict from each input transaction
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && din_bus.ready;
		if (arst_n) begin
			if (dout_bus.valid && dout_bus.ready) begin
				if (expected_text.size() == 0) begin
					flag_error($sformatf("unexpected character %h last_char %b",
						dout_bus.out_char, dout_bus.last_char));
				end else begin
					want = expected_text.pop_front();
					if (dout_bus.out_char !== want.ch)
						flag_error($sformatf("out_char expected %h, got %h",
							want.ch, dout_bus.out_char));
					if (dout_bus.last_char !== want.last)
						flag_error($sformatf("last_char expected %b, got %b (char %h)",
							want.last, dout_bus.last_char, want.ch));
				end
			end
			if (in_valid && din_bus.ready)
				format_text(in_action, in_value);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int          n;
		logic [2:0]  act;
		logic [63:0] val;

		// Directed items: field extremes, every action and the corner cases
		push_req(iafmt_pkg::ACT_SDEC, 64'h0);
		push_req(iafmt_pkg::ACT_SDEC, 64'hFFFF_FFFF_7FFF_FFFF);
		push_req(iafmt_pkg::ACT_SDEC, 64'h0000_0000_8000_0000);
		push_req(iafmt_pkg::ACT_SDEC, 64'h1234_5678_FFFF_FFFF);
		push_req(iafmt_pkg::ACT_UDEC, 64'h0);
		push_req(iafmt_pkg::ACT_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
		push_req(iafmt_pkg::ACT_UDEC, 64'h0000_0000_3B9A_CA00);
		push_req(iafmt_pkg::ACT_OCT, 64'hFFFF_FFFF_0000_0000);
		push_req(iafmt_pkg::ACT_OCT, 64'h0000_0000_FFFF_FFFF);
		push_req(iafmt_pkg::ACT_OCT, 64'h0000_0000_0000_0008);
		push_req(iafmt_pkg::ACT_HEX, 64'h0);
		push_req(iafmt_pkg::ACT_HEX, 64'h0000_0000_FFFF_FFFF);
		push_req(iafmt_pkg::ACT_HEX, 64'hABCD_0000_DEAD_BEEF);
		push_req(iafmt_pkg::ACT_PTR, 64'h0);
		push_req(iafmt_pkg::ACT_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
		push_req(iafmt_pkg::ACT_PTR, 64'h0000_0000_0000_0001);
		push_req(iafmt_pkg::ACT_PTR, 64'hFFFF_FFFF_0000_0000);
		push_req(iafmt_pkg::ACT_PTR, 64'h8000_0000_0000_0000);
		push_req(iafmt_pkg::ACT_CHAR, 64'h0);
		push_req(iafmt_pkg::ACT_CHAR, 64'hFFFF_FFFF_FFFF_FFFF);
		push_req(iafmt_pkg::ACT_CHAR, 64'h5555_AAAA_0000_0041);
		push_req(3'd6, 64'h0000_0000_0000_0005);
		push_req(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		push_req(iafmt_pkg::ACT_SDEC, 64'h0000_0000_0000_0009);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			act = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) :
				3'($urandom_range(0, 5));
			case ($urandom_range(0, 4))
				0: val = {$urandom, $urandom};
				1: val = {$urandom, 32'($urandom_range(0, 999))};
				2: val = 64'd1 << $urandom_range(0, 63);
				3: val = {$urandom, $urandom} >> $urandom_range(0, 63);
				default: val = {$urandom, -32'($urandom_range(1, 1000))};
			endcase
			push_req(act, val);
			// dropped actions do not count toward the random total
			if (act <= iafmt_pkg::ACT_CHAR)
				n++;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (req_queue.size() == 0);
		do @(posedge clk); while (in_valid && !din_bus.ready);
		@(posedge clk);
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_text.size() != 0)
			flag_error($sformatf("%0d characters never arrived", expected_text.size()));
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
